>>> src/tkm_pkg.sv
// Shared types and constants of the trie keyword matcher.
`default_nettype none

package tkm_pkg;

    // Character width and trie alphabet size (column 0 is the end marker).
    localparam int CH_W     = 7;
    localparam int ALPHABET = 128;

    // Field widths of the result item.
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;
    localparam int USED_W   = 9;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    // One input character with its command.
    typedef struct packed {
        logic               cmd;
        logic [CH_W-1:0]    ch;
        logic               last;
        logic [INDEX_W-1:0] field_value;
    } tkm_item_t;

    // One result, produced for the last character of a string.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  field_index;
        logic [USED_W-1:0]   used_states;
    } tkm_result_t;

endpackage

`default_nettype wire

>>> src/tkm_table.sv
// Transition table memory with a clearing pass after reset.
`default_nettype none

module tkm_table #(
    parameter int AW = 16,
    parameter int EW = 9
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          re,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [EW-1:0] wdata,
    output logic      [EW-1:0] rdata,
    output logic               busy
);

    localparam int DEPTH = 2 ** AW;

    logic [EW-1:0] mem [DEPTH];
    logic [AW-1:0] clr_addr_reg;
    logic          clearing_reg;

    // Clearing pass: one entry per cycle from address zero to the top.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Single port: the clearing pass owns the port while it runs.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // Registered read data, held until the next read.
    always_ff @(posedge clk)
    begin
        if (re && !clearing_reg)
        begin
            rdata <= mem[addr];
        end
    end

    assign busy = clearing_reg;

endmodule

`default_nettype wire

>>> src/tkm_walk.sv
// Walk controller: follows, allocates and marks trie transitions.
`default_nettype none

module tkm_walk #(
    parameter int NUM_STATES = 512,
    parameter int SW         = 9,
    parameter int EW         = 9
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire tkm_pkg::tkm_item_t   item,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output tkm_pkg::tkm_result_t      result,
    input  wire logic                 mem_busy,
    output logic                      mem_re,
    output logic                      mem_we,
    output logic [SW+tkm_pkg::CH_W-1:0] mem_addr,
    output logic [EW-1:0]             mem_wdata,
    input  wire logic [EW-1:0]        mem_rdata
);

    localparam int CW = tkm_pkg::CH_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STEP = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_LOOK = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [SW-1:0]        pos_reg, pos_next;
    logic                 failed_reg, failed_next;
    logic [SW-1:0]        cnt_reg, cnt_next;
    tkm_pkg::tkm_item_t   cur_reg, cur_next;
    logic                 out_valid_reg, out_valid_next;
    tkm_pkg::tkm_result_t out_reg, out_next;

    logic                 accept;
    logic                 out_free;
    logic                 emit;
    tkm_pkg::tkm_result_t emit_data;
    logic [EW-1:0]        marker_m1;

    assign item_ready = (state_reg == S_IDLE) && !mem_busy;
    assign accept     = item_valid && item_ready;
    assign out_free   = !out_valid_reg || result_ready;
    assign marker_m1  = mem_rdata - EW'(1);

    // Next-state logic of the walk.
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        failed_next    = failed_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = '0;
        mem_wdata      = '0;
        emit           = 1'b0;
        emit_data      = '0;
        emit_data.used_states = tkm_pkg::USED_W'(cnt_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cur_next = item;
                    if (!failed_reg && (item.ch != '0))
                    begin
                        // Fetch the transition for this character.
                        mem_re     = 1'b1;
                        mem_addr   = {pos_reg, item.ch};
                        state_next = S_STEP;
                    end
                    else if (item.last)
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_STEP:
            begin
                // Follow an existing edge, allocate a new state, or fail.
                if (mem_rdata != '0)
                begin
                    pos_next = mem_rdata[SW-1:0];
                end
                else if ((cur_reg.cmd == tkm_pkg::CMD_INSERT) &&
                         (cnt_reg < SW'(NUM_STATES - 1)))
                begin
                    cnt_next  = cnt_reg + SW'(1);
                    pos_next  = cnt_reg + SW'(1);
                    mem_we    = 1'b1;
                    mem_addr  = {pos_reg, cur_reg.ch};
                    mem_wdata = EW'(cnt_reg + SW'(1));
                end
                else
                begin
                    failed_next = 1'b1;
                end
                state_next = cur_reg.last ? S_FIN : S_IDLE;
            end

            S_FIN:
            begin
                if (cur_reg.cmd == tkm_pkg::CMD_INSERT)
                begin
                    if (out_free)
                    begin
                        emit = 1'b1;
                        if (failed_reg)
                        begin
                            emit_data.status = tkm_pkg::ST_FULL;
                        end
                        else
                        begin
                            // Store the pattern index plus one in the end marker.
                            emit_data.status = tkm_pkg::ST_OK;
                            mem_we    = 1'b1;
                            mem_addr  = {pos_reg, CW'(0)};
                            mem_wdata = EW'(cur_reg.field_value) + EW'(1);
                        end
                    end
                end
                else if (failed_reg)
                begin
                    if (out_free)
                    begin
                        emit             = 1'b1;
                        emit_data.status = tkm_pkg::ST_NO_MATCH;
                    end
                end
                else
                begin
                    // Fetch the end marker of the node reached.
                    mem_re     = 1'b1;
                    mem_addr   = {pos_reg, CW'(0)};
                    state_next = S_LOOK;
                end
            end

            S_LOOK:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (mem_rdata == '0)
                    begin
                        emit_data.status = tkm_pkg::ST_NO_MATCH;
                    end
                    else
                    begin
                        emit_data.status      = tkm_pkg::ST_OK;
                        emit_data.field_index = marker_m1[tkm_pkg::INDEX_W-1:0];
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A result loaded into the output register ends the string and returns the walk to the root.
        if (emit)
        begin
            pos_next    = '0;
            failed_next = 1'b0;
            state_next  = S_IDLE;
        end
    end

    // Output register: loads a result or drains on transfer.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;
        if (emit)
        begin
            out_next       = emit_data;
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            failed_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            failed_reg    <= failed_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

>>> src/trie_keyword_matcher_top.sv
// Top level of the trie keyword matcher.
//
//  Channel   Direction  Handshake                    Payload
//  item      in         item_valid / item_ready      tkm_item_t (cmd, ch, last, field_value)
//  result    out        result_valid / result_ready  tkm_result_t (status, field_index,
//                                                    used_states)
//
// A character that moves the walk is handled as the table read at the transfer and then the
// follow or allocate step on the registered read data of the single table port.
// The last character of a string adds the finish step, and a lookup also a step that reads the end marker.
// After reset a clearing pass zeroes all 128 * 2**$clog2(NUM_STATES) entries, one per cycle
// (65536 entries at the default size), while item_ready stays low.
// A waiting result blocks only the loading of the next result until it has been transferred.
`default_nettype none

module trie_keyword_matcher_top #(
    parameter int NUM_STATES = 512
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire tkm_pkg::tkm_item_t   item,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output tkm_pkg::tkm_result_t      result
);

    localparam int SW = $clog2(NUM_STATES);
    localparam int EW = (SW > 9) ? SW : 9;
    localparam int AW = SW + tkm_pkg::CH_W;

    logic          mem_busy;
    logic          mem_re;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [EW-1:0] mem_wdata;
    logic [EW-1:0] mem_rdata;

    // Transition table.
    tkm_table #(
        .AW (AW),
        .EW (EW)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .re    (mem_re),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    // Walk controller.
    tkm_walk #(
        .NUM_STATES (NUM_STATES),
        .SW         (SW),
        .EW         (EW)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .mem_busy     (mem_busy),
        .mem_re       (mem_re),
        .mem_we       (mem_we),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .mem_rdata    (mem_rdata)
    );

endmodule

`default_nettype wire

>>> dv/trie_keyword_matcher_top_test.sv
// Self-checking testbench of the trie keyword matcher: directed table, then random strings.
module trie_keyword_matcher_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TRIE_STATES = 512;
    localparam int PATTERN_MAX = 8;
    localparam int KEEP_KEYS   = 48;

    // One row of the directed table; pinned rows carry the expected result written out.
    typedef struct packed {
        logic                         cmd;
        logic [tkm_pkg::CH_W-1:0]     ch;
        logic                         last;
        logic [tkm_pkg::INDEX_W-1:0]  fval;
        logic                         pinned;
        logic [tkm_pkg::STATUS_W-1:0] status;
        logic [tkm_pkg::INDEX_W-1:0]  index;
        logic [tkm_pkg::USED_W-1:0]   used;
    } directed_row_t;

    // A key or pattern of up to eight characters.
    typedef struct packed {
        logic [3:0]                                 len;
        logic [PATTERN_MAX-1:0][tkm_pkg::CH_W-1:0] chars;
    } key_t;

    localparam int DIRECTED_ROWS = 22;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Lookup right after reset finds nothing.
        '{tkm_pkg::CMD_LOOKUP, 7'h61, 1'b1, 8'h00, 1'b1, tkm_pkg::ST_NO_MATCH, 8'h00, 9'd0},
        // A zero character marks the root itself.
        '{tkm_pkg::CMD_INSERT, 7'h00, 1'b1, 8'hFF, 1'b1, tkm_pkg::ST_OK,       8'h00, 9'd0},
        '{tkm_pkg::CMD_LOOKUP, 7'h00, 1'b1, 8'h00, 1'b1, tkm_pkg::ST_OK,       8'hFF, 9'd0},
        // Extreme characters, index zero.
        '{tkm_pkg::CMD_INSERT, 7'h01, 1'b0, 8'h00, 1'b0, tkm_pkg::ST_OK,       8'h00, 9'd0},
        '{tkm_pkg::CMD_INSERT, 7'h7F, 1'b1, 8'h00, 1'b1, tkm_pkg::ST_OK,       8'h00, 9'd2},
        '{tkm_pkg::CMD_LOOKUP, 7'h01, 1'b0, 8'h00, 1'b0, tkm_pkg::ST_OK,       8'h00, 9'd0},
        '{tkm_pkg::CMD_LOOKUP, 7'h7F, 1'b1, 8'h00, 1'b1, tkm_pkg::ST_OK,       8'h00, 9'd2},
        // A prefix of a pattern is not a match.
        '{tkm_pkg::CMD_LOOKUP, 7'h01, 1'b1, 8'h00, 1'b1, tkm_pkg::ST_NO_MATCH, 8'h00, 9'd2},
        // Missing transition on lookup.
        '{tkm_pkg::CMD_LOOKUP, 7'h7F, 1'b0, 8'h00, 1'b0, tkm_pkg::ST_OK,       8'h00, 9'd0},
        '{tkm_pkg::CMD_LOOKUP, 7'h01, 1'b1, 8'h00, 1'b1, tkm_pkg::ST_NO_MATCH, 8'h00, 9'd2},
        // Reinsert overwrites the stored index.
        '{tkm_pkg::CMD_INSERT, 7'h01, 1'b0, 8'h55, 1'b0, tkm_pkg::ST_OK,       8'h00, 9'd0},
        '{tkm_pkg::CMD_INSERT, 7'h7F, 1'b1, 8'hAA, 1'b0, tkm_pkg::ST_OK,       8'h00, 9'd0},
        '{tkm_pkg::CMD_LOOKUP, 7'h01, 1'b0, 8'h00, 1'b0, tkm_pkg::ST_OK,       8'h00, 9'd0},
        '{tkm_pkg::CMD_LOOKUP, 7'h7F, 1'b1, 8'h00, 1'b0, tkm_pkg::ST_OK,       8'h00, 9'd0},
        // Mixed commands: a failed lookup step poisons the insert that follows.
        '{tkm_pkg::CMD_INSERT, 7'h78, 1'b0, 8'h01, 1'b0, tkm_pkg::ST_OK,       8'h00, 9'd0},
        '{tkm_pkg::CMD_LOOKUP, 7'h79, 1'b0, 8'h02, 1'b0, tkm_pkg::ST_OK,       8'h00, 9'd0},
        '{tkm_pkg::CMD_INSERT, 7'h7A, 1'b1, 8'h12, 1'b0, tkm_pkg::ST_OK,       8'h00, 9'd0},
        // Lookup steps then insert steps, with a zero character in the middle.
        '{tkm_pkg::CMD_LOOKUP, 7'h01, 1'b0, 8'h00, 1'b0, tkm_pkg::ST_OK,       8'h00, 9'd0},
        '{tkm_pkg::CMD_INSERT, 7'h00, 1'b0, 8'h00, 1'b0, tkm_pkg::ST_OK,       8'h00, 9'd0},
        '{tkm_pkg::CMD_INSERT, 7'h71, 1'b1, 8'h80, 1'b0, tkm_pkg::ST_OK,       8'h00, 9'd0},
        '{tkm_pkg::CMD_LOOKUP, 7'h01, 1'b0, 8'h00, 1'b0, tkm_pkg::ST_OK,       8'h00, 9'd0},
        '{tkm_pkg::CMD_LOOKUP, 7'h71, 1'b1, 8'h00, 1'b0, tkm_pkg::ST_OK,       8'h00, 9'd0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    tkm_pkg::tkm_item_t   item = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    tkm_pkg::tkm_result_t result;

    // Predicted trie contents and walk state.
    logic [8:0]  trie_next [TRIE_STATES*tkm_pkg::ALPHABET];
    int          walk_at;
    bit          walk_lost;
    int          alloc_count;

    tkm_pkg::tkm_result_t awaited_results [$];
    key_t                 known_keys [$];
    int                   sent_items;
    int                   fail_count;
    int                   gap_pct;
    int                   stall_pct;

    trie_keyword_matcher_top #(
        .NUM_STATES(TRIE_STATES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the predicted trie by one character; returns 1 when a result is due.
    function automatic bit trie_step_result(input tkm_pkg::tkm_item_t it,
                                            output tkm_pkg::tkm_result_t res);
        int slot;
        int marker;
        res = '0;
        if (!walk_lost && it.ch != 0)
        begin
            slot = walk_at * tkm_pkg::ALPHABET + int'(it.ch);
            if (trie_next[slot] != 0)
            begin
                walk_at = int'(trie_next[slot]);
            end
            else if (it.cmd == tkm_pkg::CMD_INSERT && alloc_count + 1 < TRIE_STATES)
            begin
                alloc_count++;
                trie_next[slot] = alloc_count[8:0];
                walk_at = alloc_count;
            end
            else
            begin
                walk_lost = 1'b1;
            end
        end
        if (!it.last)
        begin
            return 1'b0;
        end
        if (it.cmd == tkm_pkg::CMD_INSERT)
        begin
            if (walk_lost)
            begin
                res.status = tkm_pkg::ST_FULL;
            end
            else
            begin
                trie_next[walk_at * tkm_pkg::ALPHABET] = 9'(int'(it.field_value) + 1);
                res.status = tkm_pkg::ST_OK;
            end
        end
        else
        begin
            marker = walk_lost ? 0 : int'(trie_next[walk_at * tkm_pkg::ALPHABET]);
            if (marker == 0)
            begin
                res.status = tkm_pkg::ST_NO_MATCH;
            end
            else
            begin
                res.status = tkm_pkg::ST_OK;
                res.field_index = 8'(marker - 1);
            end
        end
        res.used_states = alloc_count[8:0];
        walk_at = 0;
        walk_lost = 1'b0;
        return 1'b1;
    endfunction

    // Offer one character, wait for its transfer, then record what it should produce.
    task automatic transfer_item(input tkm_pkg::tkm_item_t it, input logic pinned,
                                 input tkm_pkg::tkm_result_t pinned_res);
        tkm_pkg::tkm_result_t res;
        while ($urandom_range(99) < gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (!item_ready);
        sent_items++;
        if (trie_step_result(it, res))
        begin
            awaited_results.push_back(pinned ? pinned_res : res);
        end
    endtask

    // Hold the sender idle until every predicted result has been transferred.
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Random key: mostly a four-letter alphabet so that strings share prefixes; wide keys use any nonzero character.
    function automatic key_t random_key(input bit wide);
        key_t key;
        key = '0;
        key.len = ($urandom_range(9) == 0) ? 4'($urandom_range(PATTERN_MAX, 6))
                                           : 4'($urandom_range(4, 1));
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (wide)
            begin
                key.chars[i] = 7'($urandom_range(127, 1));
            end
            else if ($urandom_range(4) == 0)
            begin
                key.chars[i] = 7'($urandom_range(127));
            end
            else
            begin
                key.chars[i] = 7'(8'h61 + $urandom_range(3));
            end
        end
        return key;
    endfunction

    // Send the first count characters of a key; mixing flips the command of some inner steps.
    task automatic send_string(input logic cmd, input key_t key, input int count,
                               input bit mixing);
        tkm_pkg::tkm_item_t it;
        for (int i = 0; i < count; i++)
        begin
            it.cmd = (mixing && i != count - 1 && $urandom_range(3) == 0) ? ~cmd : cmd;
            it.ch = key.chars[i];
            it.last = (i == count - 1);
            it.field_value = 8'($urandom_range(255));
            transfer_item(it, 1'b0, '0);
        end
    endtask

    task automatic remember_key(input key_t key);
        known_keys.push_back(key);
        if (known_keys.size() > KEEP_KEYS)
        begin
            void'(known_keys.pop_front());
        end
    endtask

    // Random mix of inserts, hits, prefixes, misses and reinserts until the item count.
    task automatic run_mixed(input int until_items);
        key_t key;
        int   pick;
        int   count;
        bit   mixing;
        while (sent_items < until_items)
        begin
            pick = $urandom_range(99);
            mixing = ($urandom_range(9) == 0);
            if (pick < 35 || known_keys.size() == 0)
            begin
                key = random_key(1'b0);
                send_string(tkm_pkg::CMD_INSERT, key, int'(key.len), mixing);
                remember_key(key);
            end
            else if (pick < 75)
            begin
                key = known_keys[$urandom_range(known_keys.size() - 1)];
                count = ($urandom_range(6) == 0) ? $urandom_range(int'(key.len), 1)
                                                 : int'(key.len);
                send_string(tkm_pkg::CMD_LOOKUP, key, count, mixing);
            end
            else if (pick < 90)
            begin
                key = random_key(1'b0);
                send_string(tkm_pkg::CMD_LOOKUP, key, int'(key.len), mixing);
            end
            else
            begin
                key = known_keys[$urandom_range(known_keys.size() - 1)];
                send_string(tkm_pkg::CMD_INSERT, key, int'(key.len), mixing);
            end
        end
    endtask

    // Result checker and receiver stalls.
    always @(posedge clk)
    begin : result_check
        tkm_pkg::tkm_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result: status %0d field_index %0d used_states %0d",
                       result.status, result.field_index, result.used_states);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    fail_count++;
                end
                if (result.field_index !== want.field_index)
                begin
                    $error("field_index: expected %0d, got %0d",
                           want.field_index, result.field_index);
                    fail_count++;
                end
                if (result.used_states !== want.used_states)
                begin
                    $error("used_states: expected %0d, got %0d",
                           want.used_states, result.used_states);
                    fail_count++;
                end
            end
        end
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Main sequence.
    initial
    begin
        tkm_pkg::tkm_item_t   it;
        tkm_pkg::tkm_result_t pinned_res;
        key_t                 key;
        int                   full_tries;

        foreach (trie_next[i])
        begin
            trie_next[i] = '0;
        end
        walk_at = 0;
        walk_lost = 1'b0;
        alloc_count = 0;
        sent_items = 0;
        fail_count = 0;
        gap_pct = 0;
        stall_pct = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table.
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            it.cmd = DIRECTED[r].cmd;
            it.ch = DIRECTED[r].ch;
            it.last = DIRECTED[r].last;
            it.field_value = DIRECTED[r].fval;
            pinned_res.status = DIRECTED[r].status;
            pinned_res.field_index = DIRECTED[r].index;
            pinned_res.used_states = DIRECTED[r].used;
            transfer_item(it, DIRECTED[r].pinned, pinned_res);
        end
        drain_results();

        // Random strings over the idling phases.
        run_mixed(150);
        gap_pct = 60;
        run_mixed(280);
        drain_results();
        gap_pct = 0;
        stall_pct = 60;
        run_mixed(410);
        gap_pct = 16;
        stall_pct = 16;
        run_mixed(540);
        drain_results();

        // Fill the trie with long wide keys, then keep inserting into the full table.
        gap_pct = 0;
        stall_pct = 0;
        while (alloc_count < TRIE_STATES - 1)
        begin
            key = random_key(1'b1);
            key.len = 4'(PATTERN_MAX);
            send_string(tkm_pkg::CMD_INSERT, key, PATTERN_MAX, 1'b0);
            remember_key(key);
        end
        for (full_tries = 0; full_tries < 8; full_tries++)
        begin
            key = random_key(1'b1);
            send_string(tkm_pkg::CMD_INSERT, key, int'(key.len), 1'b0);
        end
        drain_results();

        // Traffic against the full table.
        gap_pct = 16;
        stall_pct = 16;
        run_mixed(sent_items + 100);
        gap_pct = 60;
        stall_pct = 0;
        run_mixed(sent_items + 60);

        drain_results();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && awaited_results.size() == 0)
        begin
            $display("** trie_keyword_matcher_top: PASSED **");
        end
        else
        begin
            $display("** trie_keyword_matcher_top: FAILED **");
        end
        $finish;
    end

    // Watchdog; covers the clearing pass after reset many times over.
    initial
    begin
        #5_000_000;
        $display("** trie_keyword_matcher_top: FAILED **");
        $finish;
    end

endmodule
